[hw/rtl/emrg_pkg.sv]
// shared constants, types and helpers for the eller maze row generator
package emrg_pkg;

    localparam int MAX_COLS   = 32;
    localparam int LABEL_BITS = 16;
    localparam int COL_BITS   = $clog2(MAX_COLS);
    localparam int CNT_BITS   = $clog2(MAX_COLS + 1);
    localparam int CFG_BITS   = 6;
    localparam int CFG_RESET  = 32;
    localparam int FIELD_BITS = 32;

    typedef logic [LABEL_BITS-1:0] label_t;
    typedef logic [COL_BITS-1:0]   col_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;
    typedef logic [CFG_BITS-1:0]   cfg_t;
    typedef logic [MAX_COLS-1:0]   col_vec_t;

    localparam label_t LABEL_MAX = '1;

    typedef logic [1:0] store_op_t;
    localparam store_op_t OP_HOLD    = 2'd0;
    localparam store_op_t OP_STEP    = 2'd1;
    localparam store_op_t OP_RESTART = 2'd2;

    typedef struct packed {
        store_op_t op;
        logic      merge_en;
        logic      wr_en;
        label_t    wr_label;
        cnt_t      col_count;
    } emrg_ctl_t;

    function automatic cnt_t clamp_cols(input cfg_t v);
        cnt_t r;
        if (int'(v) < 2) begin
            r = cnt_t'(2);
        end else if (int'(v) > MAX_COLS) begin
            r = cnt_t'(MAX_COLS);
        end else begin
            r = cnt_t'(v);
        end
        return r;
    endfunction

endpackage

[hw/rtl/eller_maze_row_generator.sv]
// eller maze row generator top level: handshakes, column sequencer and wall registers
//
// One row goes in per input transfer and one row of walls comes out. The
// set labels sit in a 32-entry register ring that rotates by one column per
// cycle while a row is worked on, so one compare/merge unit at the head of
// the ring serves every column. A row takes two full turns of the ring: one
// for right walls and merges, one for bottom walls and fresh labels (or, on
// the last row, for closing the bottom and joining all sets). No new item is
// accepted until the row before it is through; the next item can be accepted
// in the same cycle that the result can first be taken. The result sits in an
// output register and does not hold up the next accept; a row only waits at
// its end if the previous result has not been taken. A column count write or
// a last row restarts the labels at once.
module eller_maze_row_generator
    import emrg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_BITS-1:0]  cfg_wr_data,   // column_count
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,       // random_right, random_down
    input  logic                 s_tlast,       // last_row
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata        // right_walls, bottom_walls, label_overflow, zero pad
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MERGE = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam col_t LAST_STEP = col_t'(MAX_COLS - 1);

    logic [1:0]  state_reg, state_next;
    col_t        step_reg, step_next;
    col_vec_t    rr_reg, rr_next;
    col_vec_t    rd_reg, rd_next;
    col_vec_t    right_reg, right_next;
    col_vec_t    down_reg, down_next;
    logic        last_reg, last_next;
    logic        run_open_reg, run_open_next;
    label_t      prev_label_reg, prev_label_next;
    label_t      next_label_reg, next_label_next;
    cfg_t        col_count_reg, col_count_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [71:0] m_tdata_reg, m_tdata_next;

    emrg_ctl_t   ctl;
    label_t      lab_cur;
    label_t      lab_nxt;
    cnt_t        n_eff;
    logic        col_active;
    logic        has_right;
    logic        lab_eq;
    logic        same_left;
    logic        right_bit;
    logic        down_bit;
    logic        fin_right;

    emrg_label_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .lab_cur (lab_cur),
        .lab_nxt (lab_nxt)
    );

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign n_eff      = clamp_cols(col_count_reg);
    assign col_active = cnt_t'(step_reg) < n_eff;
    assign has_right  = (cnt_t'(step_reg) + cnt_t'(1)) < n_eff;
    assign lab_eq     = lab_cur == lab_nxt;
    assign same_left  = (step_reg != '0) && (prev_label_reg == lab_cur);
    assign right_bit  = col_active && (rr_reg[0] || !has_right || lab_eq);
    assign down_bit   = col_active && rd_reg[0]
                        && ((has_right && lab_eq) || (same_left && run_open_reg));
    assign fin_right  = right_reg[0] && !(has_right && !lab_eq);

    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        rr_next         = rr_reg;
        rd_next         = rd_reg;
        right_next      = right_reg;
        down_next       = down_reg;
        last_next       = last_reg;
        run_open_next   = run_open_reg;
        prev_label_next = prev_label_reg;
        next_label_next = next_label_reg;
        col_count_next  = col_count_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        ctl.op        = OP_HOLD;
        ctl.merge_en  = 1'b0;
        ctl.wr_en     = 1'b0;
        ctl.wr_label  = next_label_reg;
        ctl.col_count = n_eff;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    rr_next       = col_vec_t'(s_tdata[31:0]);
                    rd_next       = col_vec_t'(s_tdata[63:32]);
                    last_next     = s_tlast;
                    step_next     = '0;
                    right_next    = '0;
                    down_next     = '0;
                    run_open_next = 1'b0;
                    state_next    = ST_MERGE;
                end
            end
            ST_MERGE: begin
                ctl.op       = OP_STEP;
                ctl.merge_en = col_active && !right_bit;
                right_next   = {right_bit, right_reg[MAX_COLS-1:1]};
                rr_next      = rr_reg >> 1;
                step_next    = step_reg + col_t'(1);
                if (step_reg == LAST_STEP) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                ctl.op    = OP_STEP;
                step_next = step_reg + col_t'(1);
                rd_next   = rd_reg >> 1;
                if (last_reg) begin
                    ctl.merge_en = has_right;
                    right_next   = {fin_right, right_reg[MAX_COLS-1:1]};
                    down_next    = {col_active, down_reg[MAX_COLS-1:1]};
                end else begin
                    ctl.wr_en       = down_bit;
                    right_next      = {right_reg[0], right_reg[MAX_COLS-1:1]};
                    down_next       = {down_bit, down_reg[MAX_COLS-1:1]};
                    run_open_next   = same_left ? (run_open_reg || !down_bit) : !down_bit;
                    prev_label_next = lab_cur;
                    if (down_bit && next_label_reg != LABEL_MAX) begin
                        next_label_next = next_label_reg + label_t'(1);
                    end
                end
                if (step_reg == LAST_STEP) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0,
                                     !last_reg && (next_label_reg == LABEL_MAX),
                                     32'(down_reg), 32'(right_reg)};
                    if (last_reg) begin
                        ctl.op          = OP_RESTART;
                        next_label_next = label_t'(n_eff);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            col_count_next  = cfg_wr_data;
            ctl.op          = OP_RESTART;
            ctl.col_count   = clamp_cols(cfg_wr_data);
            next_label_next = label_t'(clamp_cols(cfg_wr_data));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            col_count_reg  <= cfg_t'(CFG_RESET);
            next_label_reg <= label_t'(clamp_cols(cfg_t'(CFG_RESET)));
            last_reg       <= 1'b0;
            run_open_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            m_tvalid_reg   <= m_tvalid_next;
            col_count_reg  <= col_count_next;
            next_label_reg <= next_label_next;
            last_reg       <= last_next;
            run_open_reg   <= run_open_next;
        end
    end

    always_ff @(posedge aclk) begin
        rr_reg         <= rr_next;
        rd_reg         <= rd_next;
        right_reg      <= right_next;
        down_reg       <= down_next;
        prev_label_reg <= prev_label_next;
        m_tdata_reg    <= m_tdata_next;
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_MERGE && step_reg == '0)
        else $error("transfer accepted but merge pass did not start");

    a_final_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINAL && step_reg == LAST_STEP |=> state_reg == ST_DONE)
        else $error("bottom pass did not end in done");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done");

    a_label_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        next_label_reg >= label_t'(n_eff))
        else $error("fresh label below column count");
`endif

endmodule

[hw/rtl/emrg_label_store.sv]
// rotating set label store with parallel merge, fresh label write and restart
module emrg_label_store
    import emrg_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  emrg_ctl_t ctl,
    output label_t    lab_cur,
    output label_t    lab_nxt
);

    localparam cnt_t RESET_COLS = clamp_cols(cfg_t'(CFG_RESET));

    label_t   lab_reg  [MAX_COLS];
    label_t   lab_next [MAX_COLS];
    label_t   merged   [MAX_COLS];
    col_vec_t mask_reg;
    col_vec_t mask_next;

    assign lab_cur = lab_reg[0];
    assign lab_nxt = lab_reg[1];

    always_comb begin
        for (int i = 0; i < MAX_COLS; i++) begin
            merged[i] = (i == 0 && ctl.wr_en) ? ctl.wr_label : lab_reg[i];
            if (ctl.merge_en && mask_reg[i] && lab_reg[i] == lab_reg[1]) begin
                merged[i] = lab_reg[0];
            end
        end
    end

    always_comb begin
        lab_next  = lab_reg;
        mask_next = mask_reg;
        unique case (ctl.op)
            OP_STEP: begin
                for (int i = 0; i < MAX_COLS; i++) begin
                    lab_next[i]  = merged[(i + 1) % MAX_COLS];
                    mask_next[i] = mask_reg[(i + 1) % MAX_COLS];
                end
            end
            OP_RESTART: begin
                for (int i = 0; i < MAX_COLS; i++) begin
                    lab_next[i]  = label_t'(i);
                    mask_next[i] = i < int'(ctl.col_count);
                end
            end
            default: begin
                lab_next  = lab_reg;
                mask_next = mask_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_COLS; i++) begin
                lab_reg[i]  <= label_t'(i);
                mask_reg[i] <= i < int'(RESET_COLS);
            end
        end else begin
            lab_reg  <= lab_next;
            mask_reg <= mask_next;
        end
    end

endmodule

[tb/sv/eller_row_checker.sv]
// row checker for the eller maze row generator: predicts each row of walls and compares transfers
module eller_row_checker
    import emrg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_BITS-1:0] cfg_wr_data,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [63:0]         s_tdata,
    input  logic                s_tlast,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [71:0]         m_tdata,
    output int                  rows_pending,
    output int                  fail_count
);

    typedef struct {
        col_vec_t right_walls;
        col_vec_t bottom_walls;
        logic     label_overflow;
    } row_walls_t;

    cfg_t       col_setting;
    label_t     col_label [MAX_COLS];
    label_t     next_label;
    row_walls_t expected_rows [$];

    function automatic int used_cols();
        int v;
        v = int'(col_setting);
        if (v < 2) begin
            v = 2;
        end else if (v > MAX_COLS) begin
            v = MAX_COLS;
        end
        return v;
    endfunction

    task automatic restart_sets();
        for (int j = 0; j < MAX_COLS; j++) begin
            col_label[j] = label_t'(j);
        end
        next_label = label_t'(used_cols());
    endtask

    // relabel the right neighbor's whole set with the label of column j
    task automatic join_right(input int j, input int n);
        label_t from_lbl;
        label_t to_lbl;
        if (j + 1 >= n) begin
            return;
        end
        from_lbl = col_label[j + 1];
        to_lbl   = col_label[j];
        for (int k = 0; k < n; k++) begin
            if (col_label[k] == from_lbl) begin
                col_label[k] = to_lbl;
            end
        end
    endtask

    // true if column j's set still has an open way down besides this cell
    function automatic logic has_way_down(input int j, input int n, input col_vec_t down);
        int k;
        if (j + 1 < n && col_label[j] == col_label[j + 1]) begin
            return 1'b1;
        end
        k = j;
        while (k > 0 && col_label[k - 1] == col_label[j]) begin
            if (!down[k - 1]) begin
                return 1'b1;
            end
            k--;
        end
        return 1'b0;
    endfunction

    task automatic carve_row(input col_vec_t rnd_right, input col_vec_t rnd_down,
                             input logic last, output row_walls_t row);
        int       n;
        col_vec_t rw;
        col_vec_t bw;
        n  = used_cols();
        rw = '0;
        bw = '0;
        for (int j = 0; j < n; j++) begin
            if (rnd_right[j] || j + 1 >= n || col_label[j] == col_label[j + 1]) begin
                rw[j] = 1'b1;
            end else begin
                join_right(j, n);
            end
        end
        for (int j = 0; j < n; j++) begin
            if (rnd_down[j] && has_way_down(j, n, bw)) begin
                bw[j] = 1'b1;
            end
        end
        if (!last) begin
            for (int j = 0; j < n; j++) begin
                if (bw[j]) begin
                    col_label[j] = next_label;
                    if (next_label != LABEL_MAX) begin
                        next_label++;
                    end
                end
            end
        end else begin
            // close the floor and open every wall between different sets
            for (int j = 0; j < n; j++) begin
                bw[j] = 1'b1;
                if (j + 1 < n) begin
                    if (col_label[j] != col_label[j + 1]) begin
                        rw[j] = 1'b0;
                    end
                    join_right(j, n);
                end
            end
            restart_sets();
        end
        row.right_walls    = rw;
        row.bottom_walls   = bw;
        row.label_overflow = (next_label == LABEL_MAX);
    endtask

    always @(posedge aclk) begin : watch_ports
        row_walls_t got;
        row_walls_t want;
        if (!aresetn) begin
            col_setting = cfg_t'(CFG_RESET);
            restart_sets();
            expected_rows.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.right_walls    = m_tdata[31:0];
                got.bottom_walls   = m_tdata[63:32];
                got.label_overflow = m_tdata[64];
                if (expected_rows.size() == 0) begin
                    $error("result transfer with no row outstanding");
                    fail_count++;
                end else begin
                    want = expected_rows.pop_front();
                    if (got.right_walls !== want.right_walls) begin
                        $error("right_walls: expected %h, got %h",
                               want.right_walls, got.right_walls);
                        fail_count++;
                    end
                    if (got.bottom_walls !== want.bottom_walls) begin
                        $error("bottom_walls: expected %h, got %h",
                               want.bottom_walls, got.bottom_walls);
                        fail_count++;
                    end
                    if (got.label_overflow !== want.label_overflow) begin
                        $error("label_overflow: expected %b, got %b",
                               want.label_overflow, got.label_overflow);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                col_setting = cfg_wr_data;
                restart_sets();
            end
            if (s_tvalid && s_tready) begin
                carve_row(s_tdata[31:0], s_tdata[63:32], s_tlast, want);
                expected_rows.push_back(want);
            end
        end
        rows_pending <= expected_rows.size();
    end

endmodule

[tb/sv/tb_eller_maze_row_generator.sv]
// testbench top for the eller maze row generator: clock, reset, row stimulus and verdict
module tb_eller_maze_row_generator
    import emrg_pkg::*;
();

    logic                aclk;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [CFG_BITS-1:0] cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [63:0]         s_tdata     = '0;   // random_right, random_down
    logic                s_tlast     = 1'b0; // last_row
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [71:0]         m_tdata;            // right_walls, bottom_walls, label_overflow, zero pad

    int   rows_pending;
    int   fail_count;
    int   burst_left = 0;
    int   ready_left = 0;
    logic ready_level;

    eller_maze_row_generator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    eller_row_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .rows_pending (rows_pending),
        .fail_count   (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #6_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: ready stretches and stalls of random length
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_level = ($urandom_range(0, 3) != 0);
            ready_left  = ready_level ? $urandom_range(1, 60) : $urandom_range(1, 12);
            m_tready <= ready_level;
        end else begin
            ready_left = ready_left - 1;
        end
    end

    function automatic col_vec_t rand_bits();
        case ($urandom_range(0, 7))
            0: return $urandom & $urandom;
            1: return $urandom | $urandom;
            2: return $urandom & $urandom & $urandom;
            3: return '0;
            4: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_row(input col_vec_t rnd_right, input col_vec_t rnd_down,
                            input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rnd_down, rnd_right};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic wait_idle();
        @(posedge aclk);
        while (rows_pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic set_columns(input cfg_t value);
        s_tvalid <= 1'b0;
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        burst_left = 0;
    endtask

    initial begin
        int   col_plan [8];
        cfg_t value;
        col_plan = '{2, 32, 0, 63, 1, 33, 0, 0};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset column count
        send_row('0, '0, 1'b0);
        send_row('1, '1, 1'b0);
        send_row('0, '1, 1'b0);
        send_row('1, '0, 1'b0);
        send_row(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        send_row(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        send_row('0, '0, 1'b1);
        send_row('1, '1, 1'b0);
        send_row('1, '1, 1'b1);
        send_row('0, '1, 1'b0);
        send_row('0, '1, 1'b1);

        // narrowest maze
        set_columns(cfg_t'(2));
        send_row('0, '0, 1'b0);
        send_row('1, '1, 1'b0);
        send_row(32'h1, 32'h2, 1'b0);
        send_row(32'h2, 32'h1, 1'b0);
        send_row(32'hFFFF_FFFC, '1, 1'b0);
        send_row('1, '1, 1'b1);

        // count above range clamps to the full width
        set_columns(cfg_t'(63));
        send_row('0, '1, 1'b0);
        send_row('1, '0, 1'b1);

        // long maze that hands out many fresh labels
        set_columns(cfg_t'(32));
        for (int k = 0; k < 200; k++) begin
            if (k % 8 == 7) begin
                send_row($urandom & $urandom, $urandom | $urandom, 1'b0);
            end else begin
                send_row('0, '1, 1'b0);
            end
        end
        send_row($urandom, $urandom, 1'b1);

        // random mazes over several column counts
        for (int p = 0; p < 8; p++) begin
            value = (p < 6) ? cfg_t'(col_plan[p]) :
                    (p == 6) ? cfg_t'($urandom_range(2, 32)) : cfg_t'($urandom_range(0, 63));
            set_columns(value);
            for (int k = 0; k < 85; k++) begin
                if ($urandom_range(0, 15) == 0) begin
                    send_row($urandom, $urandom, 1'($urandom_range(0, 1)));
                end else begin
                    send_row(rand_bits(), rand_bits(), $urandom_range(0, 11) == 0);
                end
            end
        end

        s_tvalid <= 1'b0;
        wait_idle();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/emrg_pkg.sv
hw/rtl/emrg_label_store.sv
hw/rtl/eller_maze_row_generator.sv
tb/sv/eller_row_checker.sv
tb/sv/tb_eller_maze_row_generator.sv
